### rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator package
// Shared widths, defaults and the records passed along the cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int MEM_WORDS_DEF  = 4096;

  localparam int SIZE_W = 12;
  localparam int ADDR_W = 12;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 4;
  // internal block index, wide enough for the largest table
  localparam int BIDX_W = 8;

  localparam logic [CNT_W-1:0] CNT_RST = 5'd16;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [BIDX_W-1:0] best_idx;
    logic [SIZE_W-1:0] best_size;
    logic [ADDR_W-1:0] best_addr;
    logic [SIZE_W-1:0] req;
    logic [CNT_W-1:0]  count;
  } scan_rec_t;

  typedef struct packed {
    logic              en;
    logic [BIDX_W-1:0] idx;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } cell_wr_t;

endpackage

`default_nettype wire

### rtl/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator
// Table of free blocks in a row of cells; requests pick the smallest fit.
// ----------------------------------------------------------------------------
// Load word: result in the cycle after acceptance; next word while out_ready is high.
// Request word: the search record passes the head register, every cell and then
//   the result register; no new word is accepted while the search runs.
// Reset: clears handshake and scan control, blocks_in_use returns to 16;
//   table entries are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_block_allocator #(
  parameter int NUM_BLOCKS = bfa_pkg::NUM_BLOCKS_DEF,
  parameter int MEM_WORDS  = bfa_pkg::MEM_WORDS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_wr_en,
  input  wire [bfa_pkg::CNT_W-1:0]   cfg_wr_data,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_action,
  input  wire [bfa_pkg::IDX_W-1:0]   in_entry_index,
  input  wire [bfa_pkg::SIZE_W-1:0]  in_entry_free_size,
  input  wire [bfa_pkg::ADDR_W-1:0]  in_entry_start,
  input  wire [bfa_pkg::SIZE_W-1:0]  in_request_size,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic                       out_granted,
  output logic [bfa_pkg::IDX_W-1:0]  out_block_number,
  output logic [bfa_pkg::ADDR_W-1:0] out_start_address,
  output logic [bfa_pkg::SIZE_W-1:0] out_remaining_free
);

  localparam int SW = bfa_pkg::ADDR_W + 1;
  // address wrap, MEM_WORDS a power of two
  localparam logic [SW-1:0] WRAP_MASK = SW'(MEM_WORDS - 1);

  logic [bfa_pkg::CNT_W-1:0] biu_r;
  logic                      busy_r;
  logic                      busy_nxt;
  bfa_pkg::scan_rec_t        hd_r;
  bfa_pkg::scan_rec_t        hd_nxt;
  bfa_pkg::scan_rec_t        chain [NUM_BLOCKS+1];
  bfa_pkg::scan_rec_t        fin;
  bfa_pkg::cell_wr_t         wr;

  logic                       in_acc;
  logic                       ld_acc;
  logic                       rq_acc;
  logic [SW-1:0]              sum;
  logic [bfa_pkg::ADDR_W-1:0] addr_new;
  logic [bfa_pkg::SIZE_W-1:0] size_new;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       out_granted_r;
  logic [bfa_pkg::IDX_W-1:0]  out_block_r;
  logic [bfa_pkg::ADDR_W-1:0] out_start_r;
  logic [bfa_pkg::SIZE_W-1:0] out_rem_r;

  assign in_ready = !busy_r && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign ld_acc   = in_acc && (in_action == bfa_pkg::ACT_LOAD);
  assign rq_acc   = in_acc && (in_action == bfa_pkg::ACT_REQUEST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r <= bfa_pkg::CNT_RST;
    end else if (cfg_wr_en) begin
      biu_r <= cfg_wr_data;
    end
  end

  always_comb begin
    hd_nxt       = '0;
    hd_nxt.valid = rq_acc;
    hd_nxt.req   = in_request_size;
    hd_nxt.count = biu_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_r <= '0;
    end else begin
      hd_r <= hd_nxt;
    end
  end

  assign chain[0] = hd_r;

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    bfa_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .rec_in  (chain[i]),
      .rec_out (chain[i+1])
    );
  end

  assign fin      = chain[NUM_BLOCKS];
  assign sum      = {1'b0, fin.best_addr} + {1'b0, fin.req};
  assign addr_new = bfa_pkg::ADDR_W'(sum & WRAP_MASK);
  assign size_new = fin.best_size - fin.req;

  always_comb begin
    if (busy_r) begin
      wr.en   = fin.valid && fin.found;
      wr.idx  = fin.best_idx;
      wr.size = size_new;
      wr.addr = addr_new;
    end else begin
      wr.en   = ld_acc;
      wr.idx  = bfa_pkg::BIDX_W'(in_entry_index);
      wr.size = in_entry_free_size;
      wr.addr = in_entry_start;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (rq_acc) begin
      busy_nxt = 1'b1;
    end else if (fin.valid) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld_acc || fin.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_acc) begin
      out_granted_r <= 1'b0;
      out_block_r   <= '0;
      out_start_r   <= '0;
      out_rem_r     <= '0;
    end else if (fin.valid) begin
      out_granted_r <= fin.found;
      out_block_r   <= fin.found ? bfa_pkg::IDX_W'(fin.best_idx) : '0;
      out_start_r   <= fin.found ? fin.best_addr : '0;
      out_rem_r     <= fin.found ? size_new : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted        = out_granted_r;
  assign out_block_number   = out_block_r;
  assign out_start_address  = out_start_r;
  assign out_remaining_free = out_rem_r;

endmodule

`default_nettype wire

### rtl/bfa_cell.sv
// ----------------------------------------------------------------------------
// Best-fit allocator cell
// Holds one table entry and refines the passing best-fit record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfa_cell #(
  parameter int IDX = 0
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire bfa_pkg::cell_wr_t  wr,
  input  wire bfa_pkg::scan_rec_t rec_in,
  output bfa_pkg::scan_rec_t      rec_out
);

  localparam int CW = bfa_pkg::BIDX_W + 1;

  logic [bfa_pkg::SIZE_W-1:0] size_r;
  logic [bfa_pkg::ADDR_W-1:0] addr_r;
  bfa_pkg::scan_rec_t         rec_r;
  bfa_pkg::scan_rec_t         rec_nxt;

  logic in_range;
  logic take;

  assign in_range = CW'(IDX) < CW'(rec_in.count);
  // ties go to the higher index
  assign take = rec_in.valid && in_range && (size_r >= rec_in.req) &&
                (!rec_in.found || (size_r <= rec_in.best_size));

  always_comb begin
    rec_nxt = rec_in;
    if (take) begin
      rec_nxt.found     = 1'b1;
      rec_nxt.best_idx  = bfa_pkg::BIDX_W'(IDX);
      rec_nxt.best_size = size_r;
      rec_nxt.best_addr = addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == bfa_pkg::BIDX_W'(IDX))) begin
      size_r <= wr.size;
      addr_r <= wr.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_out = rec_r;

endmodule

`default_nettype wire

### rtl/bfa_checker.sv
// ----------------------------------------------------------------------------
// Best-fit allocator port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfa_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        in_action,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire                        out_granted,
  input wire [bfa_pkg::IDX_W-1:0]   out_block_number,
  input wire [bfa_pkg::ADDR_W-1:0]  out_start_address,
  input wire [bfa_pkg::SIZE_W-1:0]  out_remaining_free
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted) &&
      $stable(out_block_number) && $stable(out_start_address) &&
      $stable(out_remaining_free))
    else $error("result word changed while stalled");

  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_block_number == '0 &&
      out_start_address == '0 && out_remaining_free == '0)
    else $error("refused word carries non-zero fields");

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == bfa_pkg::ACT_REQUEST) |=> !in_ready)
    else $error("input ready during a search");

  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == bfa_pkg::ACT_LOAD) |=>
      out_valid && !out_granted)
    else $error("load not acknowledged next cycle");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_action          (in_action),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_granted        (out_granted),
  .out_block_number   (out_block_number),
  .out_start_address  (out_start_address),
  .out_remaining_free (out_remaining_free)
);

`default_nettype wire
